// ----- hdl/lfcm_pkg.sv -----
package lfcm_pkg;

   // Geometry of the curve store and the duty format
   localparam int SAMPLES   = 256;
   localparam int CHANNELS  = 5;
   localparam int FULL_DUTY = 4095;

   // Field widths of the request and response
   localparam int POS_W     = 8;
   localparam int DELTA_W   = 9;
   localparam int CH_W      = 3;
   localparam int DUTY_W    = 12;
   localparam int PCT_W     = 7;
   localparam int COLOR_W   = CHANNELS * DUTY_W;
   localparam int CSR_IDX_W = 1;

   // Brightness weighting: the color channels count half
   localparam int COLOR_CHANNELS = 3;
   localparam int PCT_SCALE      = 100;
   localparam int PCT_MAX        = 100;
   localparam int PCT_DEN        = COLOR_CHANNELS * (FULL_DUTY / 2)
                                   + (CHANNELS - COLOR_CHANNELS) * FULL_DUTY;
   localparam int SUM_W          = $clog2(PCT_DEN + 1);
   localparam int SCALED_SUM_W   = $clog2(PCT_DEN * PCT_SCALE + 1);

   // x / FULL_DUTY as (x * DUTY_RCP) >> RCP_SHIFT, exact for x < FULL_DUTY**2
   localparam int RCP_SHIFT = 36;
   localparam longint unsigned DUTY_RCP =
      ((64'd1 << RCP_SHIFT) + FULL_DUTY - 1) / FULL_DUTY;
   localparam int RCP_W    = $clog2(DUTY_RCP + 1);
   localparam int PROD_W   = 2 * DUTY_W;
   localparam int SCALED_W = PROD_W + RCP_W;

   // y / PCT_DEN as (y * PCT_RCP) >> PCT_SHIFT, exact over the percent range
   localparam int PCT_SHIFT = 35;
   localparam longint unsigned PCT_RCP =
      ((64'd1 << PCT_SHIFT) + PCT_DEN - 1) / PCT_DEN;
   localparam int PCT_RCP_W = $clog2(PCT_RCP + 1);
   localparam int PCT_YM_W  = SCALED_SUM_W + PCT_RCP_W;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [DUTY_W-1:0] duty_type;
   typedef duty_type [CHANNELS-1:0] duty_vec_type;

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_MOVE    = 2'd1,
      REQ_SET     = 2'd2,
      REQ_SET_MAX = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE = 1'b0,
      CSR_TARGET = 1'b1
   } csr_index_type;

   // Per-item side data that rides along the pipeline
   typedef struct packed {
      pos_type position;
      logic    moved;
   } meta_type;

   // Stage enables for the channel datapath
   typedef struct packed {
      logic prod;
      logic scale;
      logic duty;
   } lane_en_type;

   // Stage enables for the brightness datapath
   typedef struct packed {
      logic sum;
      logic mul;
      logic rcp;
   } pct_en_type;

endpackage

// ----- hdl/lfcm_curve_ram.sv -----
module lfcm_curve_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [lfcm_pkg::CH_W-1:0] wr_lane,
   input  lfcm_pkg::pos_type         wr_addr,
   input  lfcm_pkg::duty_type        wr_data,
   input  logic                      rd_en,
   input  lfcm_pkg::pos_type         rd_addr_a,
   input  lfcm_pkg::pos_type         rd_addr_b,
   output lfcm_pkg::duty_vec_type    rd_data_a,
   output lfcm_pkg::duty_vec_type    rd_data_b
);
   import lfcm_pkg::*;

   // One row per sample, one lane per channel
   duty_vec_type mem [SAMPLES];
   duty_vec_type rd_a_ff;
   duty_vec_type rd_b_ff;

   // Lane write, two registered reads (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < CHANNELS; k++) begin
            if (wr_lane == CH_W'(k)) begin
               mem[wr_addr][k] <= wr_data;
            end
         end
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hdl/lfcm_lane.sv -----
module lfcm_lane (
   input  logic                  clock,
   input  lfcm_pkg::lane_en_type en,
   input  lfcm_pkg::duty_type    src,
   input  lfcm_pkg::duty_type    tgt,
   input  lfcm_pkg::duty_type    curve_a,
   input  lfcm_pkg::duty_type    curve_b,
   output lfcm_pkg::duty_type    duty
);
   import lfcm_pkg::*;

   localparam int Q_W = SCALED_W - RCP_SHIFT;

   logic                swap_ff;
   duty_type            lo_ff;
   duty_type            diff_ff;
   duty_type            curve;
   logic [PROD_W-1:0]   prod_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [SCALED_W-1:0] scaled_in;
   logic [SCALED_W-1:0] scaled_ff;
   logic [Q_W-1:0]      quot;
   logic [Q_W:0]        duty_sum;
   duty_type            duty_in;
   duty_type            duty_ff;

   // Fade direction; the user must change colors only while the pipe is empty, the block does not enforce it
   always_ff @(posedge clock) begin
      swap_ff <= (src > tgt);
      lo_ff   <= (src > tgt) ? tgt : src;
      diff_ff <= (src > tgt) ? (src - tgt) : (tgt - src);
   end

   // Curve read mirrored when fading down, scaled by the span
   always_comb begin
      curve     = swap_ff ? curve_b : curve_a;
      prod_in   = PROD_W'(curve) * PROD_W'(diff_ff);
      scaled_in = SCALED_W'(prod_ff) * SCALED_W'(DUTY_RCP);
      quot      = scaled_ff[SCALED_W-1:RCP_SHIFT];
      duty_sum  = (Q_W+1)'(lo_ff) + (Q_W+1)'(quot);
      duty_in   = (duty_sum > (Q_W+1)'(FULL_DUTY)) ? DUTY_W'(FULL_DUTY)
                                                   : DUTY_W'(duty_sum);
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         prod_ff <= prod_in;
      end
      if (en.scale) begin
         scaled_ff <= scaled_in;
      end
      if (en.duty) begin
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;

endmodule

// ----- hdl/lfcm_percent.sv -----
module lfcm_percent (
   input  logic                       clock,
   input  lfcm_pkg::pct_en_type       en,
   input  lfcm_pkg::duty_vec_type     duty,
   output logic [lfcm_pkg::PCT_W-1:0] pct
);
   import lfcm_pkg::*;

   localparam int Q_W = PCT_YM_W - PCT_SHIFT;

   logic [SUM_W-1:0]        sum_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [SCALED_SUM_W-1:0] y_ff;
   logic [PCT_YM_W-1:0]     ym_ff;
   logic [Q_W-1:0]          quot;

   // Weighted sum: color channels at half duty
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         if (k < COLOR_CHANNELS) begin
            sum_in = sum_in + SUM_W'(duty[k] >> 1);
         end else begin
            sum_in = sum_in + SUM_W'(duty[k]);
         end
      end
   end

   // Scale to percent, then divide by the full weighted range
   always_ff @(posedge clock) begin
      if (en.sum) begin
         sum_ff <= sum_in;
      end
      if (en.mul) begin
         y_ff <= SCALED_SUM_W'(sum_ff) * SCALED_SUM_W'(PCT_SCALE);
      end
      if (en.rcp) begin
         ym_ff <= PCT_YM_W'(y_ff) * PCT_YM_W'(PCT_RCP);
      end
   end

   assign quot = ym_ff[PCT_YM_W-1:PCT_SHIFT];
   assign pct  = (quot > Q_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : PCT_W'(quot);

endmodule

// ----- hdl/led_fade_curve_mixer.sv -----
// Channel   Direction  Handshake                Contents
// req_*     in         req_valid / req_stall    request: curve load, move, set, set max
// rsp_*     out        rsp_valid / rsp_stall    position, moved, five duties, percent
// csr_*     in         csr_valid / csr_ready    write of source_color or target_color
//
// One request per cycle sustained without output stall; each request passes through the
// curve memory read, three lane stages (span multiply, reciprocal multiply, add and
// clamp), then weighted sum, percent scale, reciprocal multiply and the result register.
// Position update and curve load happen in the accept cycle; the curve write is
// forwarded into the same cycle's read. Reset clears position, colors and the
// pipeline; the curve memory is not cleared. A stalled output backs up stage by
// stage, so requests keep flowing until every stage holds a request.
module led_fade_curve_mixer (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic signed [lfcm_pkg::DELTA_W-1:0] req_step_delta,
   input  lfcm_pkg::pos_type               req_new_position,
   input  logic [lfcm_pkg::CH_W-1:0]       req_load_channel,
   input  lfcm_pkg::pos_type               req_load_sample,
   input  lfcm_pkg::duty_type              req_load_value,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lfcm_pkg::pos_type               rsp_position,
   output logic                            rsp_moved,
   output lfcm_pkg::duty_type              rsp_duty_ch0,
   output lfcm_pkg::duty_type              rsp_duty_ch1,
   output lfcm_pkg::duty_type              rsp_duty_ch2,
   output lfcm_pkg::duty_type              rsp_duty_ch3,
   output lfcm_pkg::duty_type              rsp_duty_ch4,
   output logic [lfcm_pkg::PCT_W-1:0]      rsp_brightness_percent,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfcm_pkg::COLOR_W-1:0]    csr_wdata
);
   import lfcm_pkg::*;

   localparam int ST_READ  = 1;
   localparam int ST_PROD  = 2;
   localparam int ST_SCALE = 3;
   localparam int ST_DUTY  = 4;
   localparam int ST_SUM   = 5;
   localparam int ST_MUL   = 6;
   localparam int ST_RCP   = 7;
   localparam int ST_OUT   = 8;

   logic [COLOR_W-1:0]     source_ff;
   logic [COLOR_W-1:0]     target_ff;
   pos_type                position_ff;
   pos_type                position_in;
   logic                   moved_in;
   logic signed [DELTA_W:0] move_sum;
   logic                   accept;
   logic                   load_ok;
   duty_type               load_val;
   pos_type                rd_addr_a;
   pos_type                rd_addr_b;
   duty_vec_type           row_a;
   duty_vec_type           row_b;
   duty_vec_type           curve_a;
   duty_vec_type           curve_b;
   duty_vec_type           lane_duty;
   logic [PCT_W-1:0]       pct;
   logic                   fwd_hit_a_ff;
   logic                   fwd_hit_b_ff;
   logic [CH_W-1:0]        fwd_ch_ff;
   duty_type               fwd_val_ff;
   logic [ST_OUT:ST_READ]  v_ff;
   logic [ST_OUT:ST_READ]  en;
   meta_type               meta_ff [ST_READ:ST_OUT];
   duty_vec_type           dcar_ff [ST_SUM:ST_OUT];
   logic [PCT_W-1:0]       pct_ff;
   lane_en_type            lane_en;
   pct_en_type             pct_en;

   // Stage enables: a stage loads when empty or when the next one moves
   always_comb begin
      en[ST_OUT] = !v_ff[ST_OUT] || !rsp_stall;
      for (int i = ST_OUT - 1; i >= ST_READ; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_stall = reset || !en[ST_READ];
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !reset;

   // Position update for the request at the port
   always_comb begin
      move_sum    = $signed({2'b00, position_ff})
                    + $signed({req_step_delta[DELTA_W-1], req_step_delta});
      position_in = position_ff;
      moved_in    = 1'b0;
      case (req_code_type'(req_type))
         REQ_LOAD: begin
            position_in = position_ff;
         end
         REQ_MOVE: begin
            if (req_step_delta != '0 && move_sum >= 0
                && move_sum <= (DELTA_W+1)'(SAMPLES - 1)) begin
               position_in = POS_W'(move_sum);
               moved_in    = 1'b1;
            end
         end
         REQ_SET: begin
            position_in = (int'(req_new_position) > SAMPLES - 1) ? POS_W'(SAMPLES - 1)
                                                                 : req_new_position;
         end
         REQ_SET_MAX: begin
            position_in = POS_W'(SAMPLES - 1);
         end
         default: begin
            position_in = position_ff;
         end
      endcase
   end

   // Curve load decode; read both the direct and the mirrored sample
   assign load_ok   = accept && (req_type == REQ_LOAD)
                      && (int'(req_load_channel) < CHANNELS);
   assign load_val  = (int'(req_load_value) > FULL_DUTY) ? DUTY_W'(FULL_DUTY)
                                                         : req_load_value;
   assign rd_addr_a = position_in;
   assign rd_addr_b = POS_W'(SAMPLES - 1) - position_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (accept) begin
         position_ff <= position_in;
      end
   end

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
         target_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE: source_ff <= csr_wdata;
            CSR_TARGET: target_ff <= csr_wdata;
            default:    source_ff <= source_ff;
         endcase
      end
   end

   lfcm_curve_ram u_ram (
      .clock     (clock),
      .wr_en     (load_ok),
      .wr_lane   (req_load_channel),
      .wr_addr   (req_load_sample),
      .wr_data   (load_val),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (row_a),
      .rd_data_b (row_b)
   );

   // Forward a load into the read it races with
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_hit_a_ff <= load_ok && (req_load_sample == rd_addr_a);
         fwd_hit_b_ff <= load_ok && (req_load_sample == rd_addr_b);
         fwd_ch_ff    <= req_load_channel;
         fwd_val_ff   <= load_val;
      end
   end

   assign lane_en = '{prod: en[ST_PROD], scale: en[ST_SCALE], duty: en[ST_DUTY]};
   assign pct_en  = '{sum: en[ST_SUM], mul: en[ST_MUL], rcp: en[ST_RCP]};

   // One interpolation lane per channel
   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      assign curve_a[k] = (fwd_hit_a_ff && fwd_ch_ff == CH_W'(k)) ? fwd_val_ff : row_a[k];
      assign curve_b[k] = (fwd_hit_b_ff && fwd_ch_ff == CH_W'(k)) ? fwd_val_ff : row_b[k];

      lfcm_lane u_lane (
         .clock   (clock),
         .en      (lane_en),
         .src     (source_ff[k*DUTY_W +: DUTY_W]),
         .tgt     (target_ff[k*DUTY_W +: DUTY_W]),
         .curve_a (curve_a[k]),
         .curve_b (curve_b[k]),
         .duty    (lane_duty[k])
      );
   end

   lfcm_percent u_percent (
      .clock (clock),
      .en    (pct_en),
      .duty  (lane_duty),
      .pct   (pct)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[ST_READ]) begin
            v_ff[ST_READ] <= accept;
         end
         for (int i = ST_READ + 1; i <= ST_OUT; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Side data, carried duties and the result register
   always_ff @(posedge clock) begin
      if (en[ST_READ]) begin
         meta_ff[ST_READ] <= '{position: position_in, moved: moved_in};
      end
      for (int i = ST_READ + 1; i <= ST_OUT; i++) begin
         if (en[i]) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
      if (en[ST_SUM]) begin
         dcar_ff[ST_SUM] <= lane_duty;
      end
      for (int i = ST_SUM + 1; i <= ST_OUT; i++) begin
         if (en[i]) begin
            dcar_ff[i] <= dcar_ff[i-1];
         end
      end
      if (en[ST_OUT]) begin
         pct_ff <= pct;
      end
   end

   assign rsp_valid              = v_ff[ST_OUT];
   assign rsp_position           = meta_ff[ST_OUT].position;
   assign rsp_moved              = meta_ff[ST_OUT].moved;
   assign rsp_duty_ch0           = dcar_ff[ST_OUT][0];
   assign rsp_duty_ch1           = dcar_ff[ST_OUT][1];
   assign rsp_duty_ch2           = dcar_ff[ST_OUT][2];
   assign rsp_duty_ch3           = dcar_ff[ST_OUT][3];
   assign rsp_duty_ch4           = dcar_ff[ST_OUT][4];
   assign rsp_brightness_percent = pct_ff;

`ifndef SYNTHESIS
   a_set_max: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_SET_MAX |=> position_ff == POS_W'(SAMPLES - 1))
      else $error("set-to-max request did not reach the last sample");

   a_move_changes: assert property (@(posedge clock) disable iff (reset)
      accept && moved_in |=> position_ff != $past(position_ff))
      else $error("applied move left the position unchanged");

   a_load_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_LOAD |=> position_ff == $past(position_ff))
      else $error("curve load moved the position");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_brightness_percent <= PCT_W'(PCT_MAX))
      else $error("brightness percent above range");

   a_full_pipe: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) |-> (req_stall == rsp_stall))
      else $error("full pipeline does not pass output stall to the request side");
`endif

endmodule

// ----- verif/led_fade_curve_mixer_tb.sv -----
module led_fade_curve_mixer_tb;
   import lfcm_pkg::*;

   // brightness weighting: red, green and blue count half
   localparam int HALF_CHANNELS = 3;
   localparam int BRIGHT_DEN    = HALF_CHANNELS * (FULL_DUTY / 2)
                                  + (CHANNELS - HALF_CHANNELS) * FULL_DUTY;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 80;

   typedef struct {
      req_code_type               kind;
      logic signed [DELTA_W-1:0]  delta;
      pos_type                    npos;
      logic [CH_W-1:0]            ch;
      pos_type                    smp;
      duty_type                   val;
   } fade_req_type;

   typedef struct {
      pos_type             position;
      logic                moved;
      duty_vec_type        duty;
      logic [PCT_W-1:0]    pct;
      logic [CHANNELS-1:0] duty_known;
      logic                pct_known;
   } fade_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_type = '0;
   logic signed [DELTA_W-1:0]  req_step_delta = '0;
   pos_type                    req_new_position = '0;
   logic [CH_W-1:0]            req_load_channel = '0;
   pos_type                    req_load_sample = '0;
   duty_type                   req_load_value = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   pos_type                    rsp_position;
   logic                       rsp_moved;
   duty_type                   rsp_duty_ch0;
   duty_type                   rsp_duty_ch1;
   duty_type                   rsp_duty_ch2;
   duty_type                   rsp_duty_ch3;
   duty_type                   rsp_duty_ch4;
   logic [PCT_W-1:0]           rsp_brightness_percent;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [COLOR_W-1:0]         csr_wdata = '0;

   // local copy of the fader state
   pos_type                    fade_pos = '0;
   logic [COLOR_W-1:0]         src_color = '0;
   logic [COLOR_W-1:0]         tgt_color = '0;
   duty_type                   curve_mem [CHANNELS*SAMPLES];
   bit                         curve_written [CHANNELS*SAMPLES];

   fade_req_type               pending_req_q [$];
   fade_rsp_type               expected_fade_q [$];
   int                         mismatches = 0;
   int                         hold_asks = 0;

   led_fade_curve_mixer dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted request to the local state and queue its result
   function automatic void predict_fade(fade_req_type r);
      fade_rsp_type e;
      int          cur;
      int          step;
      int unsigned lo, hi, swap, d, sum, idx, k, pct;
      pos_type     p;
      e.moved = 1'b0;
      cur     = fade_pos;
      step    = r.delta;
      case (r.kind)
         REQ_LOAD: begin
            // channels beyond the last one are dropped
            if (r.ch < CHANNELS) begin
               idx = r.ch * SAMPLES + r.smp;
               curve_mem[idx]     = (r.val > FULL_DUTY) ? duty_type'(FULL_DUTY) : r.val;
               curve_written[idx] = 1'b1;
            end
         end
         REQ_MOVE: begin
            // a move is taken only if it stays on the curve
            if (step > 0 && cur + step <= SAMPLES - 1) begin
               fade_pos = pos_type'(cur + step);
               e.moved  = 1'b1;
            end else if (step < 0 && cur >= -step) begin
               fade_pos = pos_type'(cur + step);
               e.moved  = 1'b1;
            end
         end
         REQ_SET: begin
            fade_pos = (r.npos > SAMPLES - 1) ? pos_type'(SAMPLES - 1) : r.npos;
         end
         default: begin
            fade_pos = pos_type'(SAMPLES - 1);
         end
      endcase

      e.position   = fade_pos;
      e.duty_known = '1;
      sum          = 0;
      for (k = 0; k < CHANNELS; k++) begin
         lo = src_color[DUTY_W*k +: DUTY_W];
         hi = tgt_color[DUTY_W*k +: DUTY_W];
         p  = fade_pos;
         // falling channel: mirrored curve, ends swapped
         if (lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
            p    = pos_type'(SAMPLES - 1 - fade_pos);
         end
         idx = k * SAMPLES + p;
         if (!curve_written[idx]) e.duty_known[k] = 1'b0;
         d = curve_mem[idx] * (hi - lo) / FULL_DUTY + lo;
         if (d > FULL_DUTY) d = FULL_DUTY;
         e.duty[k] = duty_type'(d);
         sum += (k < HALF_CHANNELS) ? d / 2 : d;
      end
      pct         = sum * 100 / BRIGHT_DEN;
      e.pct       = (pct > 100) ? 7'd100 : pct[PCT_W-1:0];
      e.pct_known = &e.duty_known;
      expected_fade_q.push_back(e);
   endfunction

   function automatic fade_req_type mk_load(int ch, int smp, int val);
      fade_req_type r;
      r.kind  = REQ_LOAD;
      r.delta = DELTA_W'($urandom);
      r.npos  = pos_type'($urandom);
      r.ch    = CH_W'(ch);
      r.smp   = pos_type'(smp);
      r.val   = duty_type'(val);
      return r;
   endfunction

   function automatic fade_req_type mk_move(int d);
      fade_req_type r;
      r       = mk_load($urandom_range(0, 7), $urandom, $urandom);
      r.kind  = REQ_MOVE;
      r.delta = DELTA_W'(d);
      return r;
   endfunction

   function automatic fade_req_type mk_set(int p);
      fade_req_type r;
      r      = mk_load($urandom_range(0, 7), $urandom, $urandom);
      r.kind = REQ_SET;
      r.npos = pos_type'(p);
      return r;
   endfunction

   function automatic fade_req_type mk_max();
      fade_req_type r;
      r      = mk_load($urandom_range(0, 7), $urandom, $urandom);
      r.kind = REQ_SET_MAX;
      return r;
   endfunction

   // Mostly moves and sets over a partly filled curve, with some reloads and junk loads
   function automatic fade_req_type random_req();
      int roll;
      int mag;
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
         roll = $urandom_range(0, 9);
         return mk_load(roll == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4),
                        $urandom_range(0, 255),
                        roll == 1 ? 0 : roll == 2 ? FULL_DUTY : $urandom_range(0, 4095));
      end else if (roll < 62) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) mag = 0;
         else if (roll < 70) mag = $urandom_range(1, 8);
         else if (roll < 76) mag = 255;
         else mag = $urandom_range(1, 255);
         return mk_move($urandom_range(0, 1) ? mag : -mag);
      end else if (roll < 88) begin
         roll = $urandom_range(0, 9);
         return mk_set(roll == 0 ? 0 : roll == 1 ? 255 : $urandom_range(0, 255));
      end
      return mk_max();
   endfunction

   // per channel: dark, full or anything between
   function automatic logic [COLOR_W-1:0] mixed_color();
      logic [COLOR_W-1:0] c;
      int                 k;
      for (k = 0; k < CHANNELS; k++) begin
         case ($urandom_range(0, 3))
            0:       c[DUTY_W*k +: DUTY_W] = '0;
            1:       c[DUTY_W*k +: DUTY_W] = duty_type'(FULL_DUTY);
            default: c[DUTY_W*k +: DUTY_W] = duty_type'($urandom);
         endcase
      end
      return c;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [COLOR_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SOURCE) src_color = data;
      else tgt_color = data;
   endtask

   // nothing queued, nothing offered, nothing outstanding, then drain time;
   // checked on the falling edge so the driver's updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_valid || expected_fade_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   // Request driver
   fade_req_type cur_req;
   int        gap_left = 0;
   int        burst_left = 0;
   int        roll_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_fade(cur_req);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
               cur_req = pending_req_q.pop_front();
               req_type         <= cur_req.kind;
               req_step_delta   <= cur_req.delta;
               req_new_position <= cur_req.npos;
               req_load_channel <= cur_req.ch;
               req_load_sample  <= cur_req.smp;
               req_load_value   <= cur_req.val;
               req_valid        <= 1'b1;
               // idle after this request: mostly none or short, a few long
               if (burst_left > 0) begin
                  burst_left--;
                  gap_left = 0;
               end else begin
                  roll_gap = $urandom_range(0, 99);
                  if (roll_gap < 3) burst_left = $urandom_range(20, 60);
                  if (roll_gap < 55) gap_left = 0;
                  else if (roll_gap < 94) gap_left = $urandom_range(1, 3);
                  else gap_left = $urandom_range(8, 40);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result checker and output stall generator
   int           stall_run = 0;
   int           free_run = 0;
   int           hold_seen = 0;
   int           roll_stall;
   fade_rsp_type exp_rsp;
   duty_vec_type got_duty;
   logic         bad;

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         got_duty = {rsp_duty_ch4, rsp_duty_ch3, rsp_duty_ch2, rsp_duty_ch1, rsp_duty_ch0};
         if (expected_fade_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result pos=%0d moved=%0d duty=%h pct=%0d",
                        $time, rsp_position, rsp_moved, got_duty, rsp_brightness_percent);
         end else begin
            exp_rsp = expected_fade_q.pop_front();
            bad = rsp_position !== exp_rsp.position || rsp_moved !== exp_rsp.moved
                  || (exp_rsp.pct_known && rsp_brightness_percent !== exp_rsp.pct);
            for (int k = 0; k < CHANNELS; k++)
               if (exp_rsp.duty_known[k] && got_duty[k] !== exp_rsp.duty[k]) bad = 1'b1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp pos=%0d moved=%0d duty=%h pct=%0d",
                           $time, exp_rsp.position, exp_rsp.moved, exp_rsp.duty,
                           exp_rsp.pct);
                  $display("%0t:          got pos=%0d moved=%0d duty=%h pct=%0d",
                           $time, rsp_position, rsp_moved, got_duty,
                           rsp_brightness_percent);
               end
            end
         end
      end

      // long hold asked for by the sequence, otherwise random stalls
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         stall_run = 150;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         rsp_stall <= 1'b0;
         if (free_run > 0) begin
            free_run--;
         end else begin
            roll_stall = $urandom_range(0, 99);
            if (roll_stall < 4) free_run = $urandom_range(20, 80);
            else if (roll_stall < 30) stall_run = $urandom_range(1, 3);
            else if (roll_stall < 33) stall_run = $urandom_range(10, 40);
         end
      end
   end

   // Stimulus sequence
   logic [COLOR_W-1:0] src, tgt;
   int                 ph, s, ch, roll_val;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_SOURCE, '0);
      write_csr(CSR_TARGET, '0);

      // fill samples 4n and 4n+3 of every channel, each mirrors onto another
      // filled one; sample 0 of all channels first, position stays 0
      for (s = 0; s < SAMPLES; s++)
         if (s % 4 == 0 || s % 4 == 3)
            for (ch = 0; ch < CHANNELS; ch++) begin
               roll_val = $urandom_range(0, 19);
               pending_req_q.push_back(mk_load(ch, s, roll_val == 0 ? 0 :
                                       roll_val == 1 ? FULL_DUTY : $urandom_range(0, 4095)));
            end
      wait_idle();

      // directed: channels 1 and 3 fall, the others rise, all end to end
      write_csr(CSR_SOURCE, 60'h000_FFF_000_FFF_000);
      write_csr(CSR_TARGET, 60'hFFF_000_FFF_000_FFF);
      pending_req_q.push_back(mk_move(0));      // zero step
      pending_req_q.push_back(mk_move(-1));     // below first sample
      pending_req_q.push_back(mk_move(255));    // up to the last sample
      pending_req_q.push_back(mk_move(1));      // past the last sample
      pending_req_q.push_back(mk_move(-255));   // back to zero
      pending_req_q.push_back(mk_set(255));
      pending_req_q.push_back(mk_set(0));
      pending_req_q.push_back(mk_max());
      pending_req_q.push_back(mk_set(128));
      pending_req_q.push_back(mk_move(-128));
      pending_req_q.push_back(mk_move(127));
      pending_req_q.push_back(mk_load(5, 255, FULL_DUTY));   // no such channel
      pending_req_q.push_back(mk_load(7, 0, 0));
      pending_req_q.push_back(mk_load(6, 128, 2730));
      pending_req_q.push_back(mk_load(4, 255, FULL_DUTY));
      pending_req_q.push_back(mk_set(0));
      pending_req_q.push_back(mk_load(0, 0, 0));             // read in the same request
      pending_req_q.push_back(mk_load(1, 255, 0));           // mirrored read, same request
      pending_req_q.push_back(mk_load(2, 0, FULL_DUTY));
      pending_req_q.push_back(mk_move(1));
      pending_req_q.push_back(mk_set(200));
      pending_req_q.push_back(mk_move(55));
      pending_req_q.push_back(mk_move(-200));
      wait_idle();

      // random phases, each under its own pair of colors
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               src = '0;
               tgt = '1;
            end
            1: begin
               src = '1;
               tgt = '0;
            end
            default: begin
               src = mixed_color();
               tgt = ($urandom_range(0, 5) == 0) ? src : mixed_color();
            end
         endcase
         write_csr(CSR_SOURCE, src);
         write_csr(CSR_TARGET, tgt);
         if (ph == 2) hold_asks = hold_asks + 1;
         repeat (PHASE_ITEMS) pending_req_q.push_back(random_req());
         wait_idle();
      end

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lfcm_pkg.sv
hdl/lfcm_curve_ram.sv
hdl/lfcm_lane.sv
hdl/lfcm_percent.sv
hdl/led_fade_curve_mixer.sv
verif/led_fade_curve_mixer_tb.sv
